### src/swac_pkg.sv
// ----------------------------------------------------------------------------
// swac_pkg: shared types and constants of the sliding window alarm counter
// Holds field widths, register indexes, reset values and the structs that
// travel between the counter's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swac_pkg;

	localparam int RD_W      = 16;
	localparam int MHC_W     = 5;
	localparam int CNT_OUT_W = 16;
	localparam int CFG_AW    = 2;
	localparam int CFG_DW    = 16;
	localparam int OUT_DW    = 24;

	typedef enum logic [CFG_AW-1:0] {
		REG_HIGH_LEVEL,
		REG_CEILING,
		REG_AVG_THRESHOLD,
		REG_MIN_HIGH_COUNT
	} reg_idx_t;

	localparam logic signed [RD_W-1:0] HIGH_LEVEL_RST     = 16'sd70;
	localparam logic signed [RD_W-1:0] CEILING_RST        = 16'sd150;
	localparam logic signed [RD_W-1:0] AVG_THRESHOLD_RST  = 16'sd90;
	localparam logic [MHC_W-1:0]       MIN_HIGH_COUNT_RST = 5'd3;

	typedef struct packed {
		logic signed [RD_W-1:0] high_level;
		logic signed [RD_W-1:0] ceiling;
		logic signed [RD_W-1:0] avg_threshold;
		logic [MHC_W-1:0]       min_high_count;
	} cfg_t;

	typedef struct packed {
		logic                 window_full;
		logic                 window_critical;
		logic [CNT_OUT_W-1:0] critical_count;
		logic                 done_res;
	} result_t;

endpackage

`default_nettype wire

### src/swac_judge.sv
// ----------------------------------------------------------------------------
// swac_judge: window judgement
// Decides whether the window made of the stored history and the new reading
// is critical under the current thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module swac_judge #(
	parameter int WINDOW = 5,
	localparam int SUM_W = swac_pkg::RD_W + $clog2(WINDOW) + 1
) (
	input  swac_pkg::cfg_t                            cfg,
	input  logic signed [swac_pkg::RD_W-1:0]          reading,
	input  logic [WINDOW-2:0][swac_pkg::RD_W-1:0]     history,
	input  logic signed [SUM_W-1:0]                   hist_sum,
	output logic                                      crit
);
	import swac_pkg::*;

	localparam int HW = $clog2(WINDOW + 1);

	logic [WINDOW-1:0]        over_v;
	logic [WINDOW-1:0]        high_v;
	logic [HW-1:0]            highs;
	logic signed [SUM_W-1:0]  win_sum;
	logic signed [SUM_W-1:0]  thr_w;

	always_comb begin
		over_v[WINDOW-1] = reading > cfg.ceiling;
		high_v[WINDOW-1] = reading >= cfg.high_level;
		for (int i = 0; i < WINDOW - 1; i++) begin
			over_v[i] = $signed(history[i]) > cfg.ceiling;
			high_v[i] = $signed(history[i]) >= cfg.high_level;
		end
	end

	assign highs   = HW'($countones(high_v));
	assign win_sum = hist_sum + SUM_W'(reading);
	// The average test is done as sum >= threshold * WINDOW, which is exact.
	assign thr_w   = SUM_W'($signed(cfg.avg_threshold)) * $signed(SUM_W'(WINDOW));

	assign crit = (over_v == '0)
		&& ((HW + MHC_W)'(highs) >= (HW + MHC_W)'(cfg.min_high_count))
		&& (win_sum >= thr_w);

endmodule

`default_nettype wire

### src/swac_state.sv
// ----------------------------------------------------------------------------
// swac_state: sequence state
// Keeps the reading history, its sum, the fill level and the saturating
// critical window count, and forms the result of each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module swac_state #(
	parameter int WINDOW     = 5,
	parameter int COUNT_BITS = 16,
	localparam int SUM_W     = swac_pkg::RD_W + $clog2(WINDOW) + 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic signed [swac_pkg::RD_W-1:0]      reading,
	input  logic                                  last,
	input  logic                                  crit,
	output logic [WINDOW-2:0][swac_pkg::RD_W-1:0] history,
	output logic signed [SUM_W-1:0]               hist_sum,
	output swac_pkg::result_t                     result
);
	import swac_pkg::*;

	localparam int FW = $clog2(WINDOW + 1);
	localparam int CW = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

	logic [WINDOW-2:0][RD_W-1:0] hist_q;
	logic signed [SUM_W-1:0]     hsum_q;
	logic [FW-1:0]               fill_q;
	logic [COUNT_BITS-1:0]       count_q;

	logic [FW-1:0]         fill_nxt;
	logic                  full;
	logic [COUNT_BITS-1:0] count_nxt;
	logic [CW-1:0]         count_ext;

	assign full     = fill_q >= FW'(WINDOW - 1);
	assign fill_nxt = full ? FW'(WINDOW) : fill_q + FW'(1);

	always_comb begin
		count_nxt = count_q;
		if (full && crit && (count_q != '1)) begin
			count_nxt = count_q + COUNT_BITS'(1);
		end
	end

	assign count_ext = CW'(count_nxt);

	always_comb begin
		result.window_full     = full;
		result.window_critical = full && crit;
		result.critical_count  = count_ext[CNT_OUT_W-1:0];
		result.done_res        = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			hsum_q  <= '0;
			fill_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (last) begin
				hist_q  <= '0;
				hsum_q  <= '0;
				fill_q  <= '0;
				count_q <= '0;
			end else begin
				for (int i = 0; i < WINDOW - 2; i++) begin
					hist_q[i] <= hist_q[i+1];
				end
				hist_q[WINDOW-2] <= reading;
				// Oldest reading leaves the sum as the new one enters.
				hsum_q  <= hsum_q + SUM_W'(reading) - SUM_W'($signed(hist_q[0]));
				fill_q  <= fill_nxt;
				count_q <= count_nxt;
			end
		end
	end

	assign history  = hist_q;
	assign hist_sum = hsum_q;

endmodule

`default_nettype wire

### src/sliding_window_alarm_counter.sv
// Result: an accepted input beat appears as its result beat on the master side in the next cycle.
// Throughput: one beat per cycle while the master side takes each result; the judgement is a
// single pass from the history registers and the incoming reading into the output register.
// Reset: arst_n clears history, fill level, count and the output valid at once, and
// loads the threshold registers with their default values.
// ----------------------------------------------------------------------------
// sliding_window_alarm_counter: alarm counter over a sliding window of readings
// Judges each window of WINDOW consecutive readings against a ceiling, a high
// level with a least count, and an average threshold, and counts critical windows
// per sequence. A beat with tlast ends the sequence and clears the history.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_alarm_counter #(
	parameter int WINDOW     = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port, index follows swac_pkg::reg_idx_t.
	input  logic                          cfg_we,
	input  logic [swac_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [swac_pkg::CFG_DW-1:0]   cfg_data,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] reading
	input  logic                          s_tlast,   // last reading of the sequence
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [swac_pkg::OUT_DW-1:0]   m_tdata,   // [0] window_full, [1] window_critical,
	                                                 // [17:2] critical_count, [23:18] zero
	output logic                          m_tlast    // done_res
);
	import swac_pkg::*;

	localparam int SUM_W = RD_W + $clog2(WINDOW) + 1;

	cfg_t                        cfg_q;
	logic                        accept;
	logic                        crit;
	logic [WINDOW-2:0][RD_W-1:0] history;
	logic signed [SUM_W-1:0]     hist_sum;
	result_t                     result;
	result_t                     result_q;
	logic                        valid_q;

	// Configuration registers. An index outside the list cannot occur with a
	// two bit index, so every write lands in one of them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_level     <= HIGH_LEVEL_RST;
			cfg_q.ceiling        <= CEILING_RST;
			cfg_q.avg_threshold  <= AVG_THRESHOLD_RST;
			cfg_q.min_high_count <= MIN_HIGH_COUNT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_HIGH_LEVEL:     cfg_q.high_level     <= $signed(cfg_data);
				REG_CEILING:        cfg_q.ceiling        <= $signed(cfg_data);
				REG_AVG_THRESHOLD:  cfg_q.avg_threshold  <= $signed(cfg_data);
				REG_MIN_HIGH_COUNT: cfg_q.min_high_count <= cfg_data[MHC_W-1:0];
				default: ;
			endcase
		end
	end

	// A new beat is taken whenever the output register is empty or is being
	// drained in this same cycle; a waiting result that is not taken stops the input.
	assign s_tready = !valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	swac_judge #(
		.WINDOW (WINDOW)
	) u_judge (
		.cfg      (cfg_q),
		.reading  ($signed(s_tdata)),
		.history  (history),
		.hist_sum (hist_sum),
		.crit     (crit)
	);

	swac_state #(
		.WINDOW     (WINDOW),
		.COUNT_BITS (COUNT_BITS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.reading  ($signed(s_tdata)),
		.last     (s_tlast),
		.crit     (crit),
		.history  (history),
		.hist_sum (hist_sum),
		.result   (result)
	);

	// Output register: holds the result beat until the master side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'd0, result_q.critical_count, result_q.window_critical,
		result_q.window_full};
	assign m_tlast  = result_q.done_res;

endmodule

`default_nettype wire

### src/swac_checker.sv
// ----------------------------------------------------------------------------
// swac_checker: port level checks of the sliding window alarm counter
// Watches the top level's ports and flags behavior the design must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module swac_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [swac_pkg::OUT_DW-1:0] m_tdata
);

	// A result beat that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// Every accepted input beat yields a result beat in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted beat produced no result");

	// The input side is never blocked while the output register is empty.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// Only a full window can be critical.
	a_crit_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
		else $error("critical flag on a window that is not full");

endmodule

bind sliding_window_alarm_counter swac_checker u_swac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
